[rtl/tlsi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tlsi_pkg;

  // Width of the position and target fields at the ports
  localparam int unsigned FieldBits = 24;

  // Item operation codes
  typedef enum logic [0:0] {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  // One input beat
  typedef struct packed {
    op_e                          operation;
    logic signed [FieldBits-1:0]  target_x;
    logic signed [FieldBits-1:0]  target_y;
    logic signed [FieldBits-1:0]  target_z;
    logic                         limit_x;
    logic                         limit_y;
    logic                         limit_z;
  } in_item_t;

  // One result beat
  typedef struct packed {
    logic                         step_x;
    logic                         step_y;
    logic                         step_z;
    logic                         dir_x;
    logic                         dir_y;
    logic                         dir_z;
    logic signed [FieldBits-1:0]  position_x;
    logic signed [FieldBits-1:0]  position_y;
    logic signed [FieldBits-1:0]  position_z;
    logic                         busy_res;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/three_axis_line_step_interpolator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake          | Beat type
// --------+-----------+--------------------+---------------------
// in      | input     | in_valid_i/stall_o | tlsi_pkg::in_item_t
// out     | output    | out_valid_o/stall_i| tlsi_pkg::out_item_t
//
// A start or a tick passes from the input register through the axis
// add/compare logic into the result register, so one beat is accepted per
// cycle while the result register is free or draining.
// rst_ni clears the control state: positions zero, all axes forward, idle.
// A stalled result holds; the input register still takes a beat while the
// result waits, and in_stall_o rises only with both registers full and the
// result stalled.

module three_axis_line_step_interpolator_unit #(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned AXIS_COUNT    = 3
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire tlsi_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output tlsi_pkg::out_item_t       out_data_o
);

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [POSITION_BITS:0]   err_t;

  // Input register
  logic                in_vld_q;
  tlsi_pkg::in_item_t  in_data_q;
  // Result register
  logic                out_vld_q;
  tlsi_pkg::out_item_t out_data_q, out_data_d;

  // Axis state
  pos_t pos_q  [3];
  pos_t pos_d  [3];
  pos_t dist_q [3];
  pos_t dist_d [3];
  err_t err_q  [3];
  err_t err_d  [3];
  logic fwd_q  [3];
  logic fwd_d  [3];
  pos_t big_q, big_d;
  pos_t iter_q, iter_d;
  logic moving_q, moving_d;

  // Per-beat working values
  logic signed [tlsi_pkg::FieldBits-1:0] tgt_in [3];
  logic                                  lim_in [3];
  pos_t diff     [3];
  pos_t new_dist [3];
  logic new_fwd  [3];
  pos_t new_big;
  err_t err_sum  [3];
  logic hit      [3];
  logic stepped  [3];
  pos_t iter_dec;

  logic fire;
  logic in_load;

  // Advance the input beat when the result register is free or draining
  assign fire       = in_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = in_vld_q & out_vld_q & out_stall_i;
  assign in_load    = in_valid_i & ~in_stall_o;

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_load) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_data_q <= in_data_i;
    end
  end

  // Start and tick arithmetic, state update and result assembly
  always_comb begin
    tgt_in[0] = in_data_q.target_x;
    tgt_in[1] = in_data_q.target_y;
    tgt_in[2] = in_data_q.target_z;
    lim_in[0] = in_data_q.limit_x;
    lim_in[1] = in_data_q.limit_y;
    lim_in[2] = in_data_q.limit_z;

    new_big  = '0;
    iter_dec = iter_q - pos_t'(1);

    for (int a = 0; a < 3; a++) begin
      // Distance and direction toward the target, wrapped to the position width
      diff[a] = pos_t'(tgt_in[a]) - pos_q[a];
      if (a < AXIS_COUNT) begin
        new_fwd[a]  = ~diff[a][POSITION_BITS-1];
        new_dist[a] = diff[a][POSITION_BITS-1] ? (pos_t'(0) - diff[a]) : diff[a];
      end else begin
        new_fwd[a]  = 1'b1;
        new_dist[a] = '0;
      end
      if (new_dist[a] > new_big) begin
        new_big = new_dist[a];
      end

      // Error accumulation for one tick
      err_sum[a] = err_q[a] + {1'b0, dist_q[a]};
      hit[a]     = (a < AXIS_COUNT) && (err_sum[a] >= {1'b0, big_q});
      stepped[a] = 1'b0;
    end

    // Hold state by default
    pos_d    = pos_q;
    dist_d   = dist_q;
    err_d    = err_q;
    fwd_d    = fwd_q;
    big_d    = big_q;
    iter_d   = iter_q;
    moving_d = moving_q;

    if (fire) begin
      if (in_data_q.operation == tlsi_pkg::OP_START) begin
        // Load a new move when idle and the move is not empty
        if (!moving_q && (new_big != '0)) begin
          for (int a = 0; a < 3; a++) begin
            dist_d[a] = new_dist[a];
            fwd_d[a]  = new_fwd[a];
            err_d[a]  = '0;
          end
          big_d    = new_big;
          iter_d   = new_big;
          moving_d = 1'b1;
        end
      end else if (moving_q) begin
        // Run one iteration; a backward axis against its limit does not step
        for (int a = 0; a < 3; a++) begin
          if (hit[a]) begin
            err_d[a] = err_sum[a] - {1'b0, big_q};
            if (fwd_q[a] || !lim_in[a]) begin
              stepped[a] = 1'b1;
              pos_d[a]   = fwd_q[a] ? (pos_q[a] + pos_t'(1)) : (pos_q[a] - pos_t'(1));
            end
          end else if (a < AXIS_COUNT) begin
            err_d[a] = err_sum[a];
          end
        end
        iter_d   = iter_dec;
        moving_d = (iter_dec != '0);
      end
    end

    // Result beat from the updated state
    out_data_d.step_x     = stepped[0];
    out_data_d.step_y     = stepped[1];
    out_data_d.step_z     = stepped[2];
    out_data_d.dir_x      = fwd_d[0];
    out_data_d.dir_y      = fwd_d[1];
    out_data_d.dir_z      = fwd_d[2];
    out_data_d.position_x = tlsi_pkg::FieldBits'(signed'(pos_d[0]));
    out_data_d.position_y = tlsi_pkg::FieldBits'(signed'(pos_d[1]));
    out_data_d.position_z = tlsi_pkg::FieldBits'(signed'(pos_d[2]));
    out_data_d.busy_res   = moving_d;
  end

  // Axis state and move control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        pos_q[a]  <= '0;
        dist_q[a] <= '0;
        err_q[a]  <= '0;
        fwd_q[a]  <= 1'b1;
      end
      big_q    <= '0;
      iter_q   <= '0;
      moving_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      dist_q   <= dist_d;
      err_q    <= err_d;
      fwd_q    <= fwd_d;
      big_q    <= big_d;
      iter_q   <= iter_d;
      moving_q <= moving_d;
    end
  end

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[rtl/tlsi_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tlsi_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire tlsi_pkg::out_item_t out_data_o
);

  // Hold a stalled result beat
  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Stall the input only while a result waits at a stalled output
  a_stall_needs_blocked_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with the result side free");

  // Leave reset with no result pending
  a_no_result_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("beat present right after reset");

endmodule

bind three_axis_line_step_interpolator_unit tlsi_checker u_tlsi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
